/* hdl/tts_pkg.sv */
// Shared types, codes and the constant sine table for the timed tone generator.
package tts_pkg;

    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_ADDR_W  = $clog2(SINE_ENTRIES);

    localparam logic [6:0] RATE_KHZ_RESET = 7'd15;

    // divider: quotient below 2^39 whenever the divisor is non-zero, as it is then at least 1000
    localparam int DIV_STEPS = 39;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } tts_op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH,
        ST_TICK
    } tts_state_t;

    typedef logic [15:0] sine_rom_t [SINE_ENTRIES];

    localparam logic [63:0] ONE_Q60    = 64'h1000000000000000;
    localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
    localparam logic [63:0] STEP_Q60   = TWO_PI_Q60 / SINE_ENTRIES;
    localparam logic [63:0] STEP_REM   = TWO_PI_Q60 % SINE_ENTRIES;

    // (a * b) >> 60, truncated, for operands below 2^62
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // floor(n / d) by shift and subtract, d non-zero
    function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Taylor series sine on [0, pi/2] in Q60
    function automatic logic [63:0] sin_q60(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] den;
        logic        done;
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        done = 1'b0;
        for (int n = 1; n < 40; n++)
        begin
            if (!done)
            begin
                den  = 64'(2 * n) * 64'(2 * n + 1);
                term = div_u64(mul_q60(term, x2), den);
                if (term == 64'd0)
                    done = 1'b1;
                else if (n[0])
                    sum = sum - term;
                else
                    sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic sine_rom_t build_rom();
        sine_rom_t   rom;
        logic [63:0] a;
        logic [63:0] s;
        logic [63:0] mag;
        logic        neg;
        for (int i = 0; i < SINE_ENTRIES; i++)
        begin
            a   = STEP_Q60 * 64'(i) + (STEP_REM * 64'(i)) / SINE_ENTRIES;
            neg = 1'b0;
            if (a > PI_Q60)
            begin
                neg = 1'b1;
                a   = a - PI_Q60;
            end
            if (a > (PI_Q60 >> 1))
                a = PI_Q60 - a;
            s = sin_q60(a);
            if (s > ONE_Q60)
                s = ONE_Q60;
            mag = ((s >> 20) * 64'd32767 + (64'd1 << 39)) >> 40;
            rom[i] = neg ? 16'(64'd0 - mag) : mag[15:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_rom();

endpackage

/* hdl/tts_if.sv */
// Handshake channels of the timed tone generator: items in, samples out, rate writes.
interface tts_item_if;
    import tts_pkg::*;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] frequency_hz;
    logic [24:0] duration_ms_q16;

    modport source (output valid, operation, frequency_hz, duration_ms_q16, input ready);
    modport sink   (input valid, operation, frequency_hz, duration_ms_q16, output ready);
endinterface

interface tts_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               last_of_tone;

    modport source (output valid, sample, last_of_tone, input ready);
    modport sink   (input valid, sample, last_of_tone, output ready);
endinterface

interface tts_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] sample_rate_khz;

    modport source (output valid, sample_rate_khz, input ready);
    modport sink   (input valid, sample_rate_khz, output ready);
endinterface

/* hdl/timed_tone_sine_generator.sv */
// Timed tone sine generator: phase-continuous sine oscillator playing timed segments.
//
// A load item is accepted, then takes 39 steps of a one-bit-per-cycle
// shift-subtract divider computing frequency * 2^32 / (rate_kHz * 1000), then a
// finish step that updates the step, sample count and residue. The input is not
// ready in that time. A tick item with samples left is accepted, then the
// registered sine ROM value moves to the output register; a tick with none left
// gives no sample. The next item is accepted while a sample waits at the output;
// a tick only stalls if the previous sample is still unread.
// Rate writes are taken at any time, but should only be made while idle.
module timed_tone_sine_generator
    import tts_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tts_cfg_if.sink       cfg,
    tts_item_if.sink      tone,
    tts_sample_if.source  samp
);

    tts_state_t state_reg, state_next;

    logic [6:0]           rate_reg;
    logic [31:0]          phase_accum_reg, phase_accum_next;
    logic [31:0]          phase_step_reg, phase_step_next;
    logic [15:0]          residue_reg, residue_next;
    logic [15:0]          samples_left_reg, samples_left_next;
    logic [DIV_CNT_W-1:0] step_cnt_reg, step_cnt_next;
    logic                 out_valid_reg, out_valid_next;

    logic [38:0]          num_reg, num_next;
    logic [16:0]          divisor_reg, divisor_next;
    logic [16:0]          rem_reg, rem_next;
    logic [31:0]          quot_reg, quot_next;
    logic [24:0]          dur_reg, dur_next;
    logic [31:0]          prod_reg;
    logic [15:0]          rom_data_reg;
    logic [15:0]          out_sample_reg, out_sample_next;
    logic                 out_last_reg, out_last_next;

    logic        in_ready;
    logic        accept;
    logic        out_free;
    logic [17:0] trial;
    logic [17:0] diff;
    logic [32:0] total;

    // ---------------- outputs ----------------
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        out_free = !out_valid_reg || samp.ready;
    end

    assign accept            = tone.valid && in_ready;
    assign tone.ready        = in_ready;
    assign cfg.ready         = 1'b1;
    assign samp.valid        = out_valid_reg;
    assign samp.sample       = out_sample_reg;
    assign samp.last_of_tone = out_last_reg;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (tone.operation == OP_LOAD)
                        state_next = ST_DIVIDE;
                    else if (samples_left_reg != 16'd0)
                        state_next = ST_TICK;
                end
            end
            ST_DIVIDE:
            begin
                if (step_cnt_reg == '0)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
                state_next = ST_IDLE;
            ST_TICK:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        trial = {rem_reg, num_reg[38]};
        diff  = trial - {1'b0, divisor_reg};
        total = {1'b0, prod_reg} + {17'd0, residue_reg};

        phase_accum_next  = phase_accum_reg;
        phase_step_next   = phase_step_reg;
        residue_next      = residue_reg;
        samples_left_next = samples_left_reg;
        step_cnt_next     = step_cnt_reg;
        num_next          = num_reg;
        divisor_next      = divisor_reg;
        rem_next          = rem_reg;
        quot_next         = quot_reg;
        dur_next          = dur_reg;
        out_sample_next   = out_sample_reg;
        out_last_next     = out_last_reg;
        out_valid_next    = out_valid_reg && !samp.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && tone.operation == OP_LOAD)
                begin
                    // top bits of the dividend go straight in as the first remainder
                    rem_next      = {8'd0, tone.frequency_hz[15:7]};
                    num_next      = {tone.frequency_hz[6:0], 32'd0};
                    divisor_next  = 17'({10'd0, rate_reg} * 17'd1000);
                    dur_next      = tone.duration_ms_q16;
                    quot_next     = '0;
                    step_cnt_next = DIV_CNT_W'(DIV_STEPS - 1);
                end
            end
            ST_DIVIDE:
            begin
                num_next = {num_reg[37:0], 1'b0};
                if (trial >= {1'b0, divisor_reg})
                begin
                    rem_next  = diff[16:0];
                    quot_next = {quot_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial[16:0];
                    quot_next = {quot_reg[30:0], 1'b0};
                end
                step_cnt_next = step_cnt_reg - DIV_CNT_W'(1);
            end
            ST_FINISH:
            begin
                phase_step_next   = (divisor_reg == 17'd0) ? 32'd0 : quot_reg;
                samples_left_next = total[32] ? 16'hFFFF : total[31:16];
                residue_next      = total[15:0];
            end
            ST_TICK:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_sample_next   = rom_data_reg;
                    out_last_next     = (samples_left_reg == 16'd1);
                    phase_accum_next  = phase_accum_reg + phase_step_reg;
                    samples_left_next = samples_left_reg - 16'd1;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rate_reg         <= RATE_KHZ_RESET;
            phase_accum_reg  <= '0;
            phase_step_reg   <= '0;
            residue_reg      <= '0;
            samples_left_reg <= '0;
            step_cnt_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_accum_reg  <= phase_accum_next;
            phase_step_reg   <= phase_step_next;
            residue_reg      <= residue_next;
            samples_left_reg <= samples_left_next;
            step_cnt_reg     <= step_cnt_next;
            out_valid_reg    <= out_valid_next;
            if (cfg.valid)
                rate_reg <= cfg.sample_rate_khz;
        end
    end

    // payload, no reset; ROM read registered from the current phase
    always_ff @(posedge clk)
    begin
        num_reg        <= num_next;
        divisor_reg    <= divisor_next;
        rem_reg        <= rem_next;
        quot_reg       <= quot_next;
        dur_reg        <= dur_next;
        prod_reg       <= 32'({25'd0, rate_reg} * {7'd0, dur_reg});
        rom_data_reg   <= SINE_ROM[phase_accum_reg[31 -: SINE_ADDR_W]];
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

    // ---------------- assertions ----------------
    a_valid_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_TICK))
        else $error("sample issued outside a tick");

    a_tick_has_samples: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK) |-> (samples_left_reg != 16'd0))
        else $error("tick started with no samples left");

    a_count_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK && out_free) |=>
            (samples_left_reg == $past(samples_left_reg) - 16'd1) && out_valid_reg)
        else $error("sample count not decremented with an issued sample");

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK && out_free && samples_left_reg == 16'd1) |=>
            out_last_reg && (samples_left_reg == 16'd0))
        else $error("last sample of tone not flagged");

endmodule
